/* hw/rtl/dwc_pkg.sv */
// Shared types, constants and helpers of the 3x3 depthwise convolution block.
package dwc_pkg;

  localparam int WIDTH_MAX_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int PIXEL_BITS    = 16;
  localparam int WEIGHT_BITS   = 16;
  localparam int PROD_BITS     = PIXEL_BITS + WEIGHT_BITS;
  localparam int SUM_BITS      = 36;
  localparam int DIM_BITS      = 11;
  localparam int ROW_BITS      = 10;
  localparam int WREG_BITS     = 48;
  localparam int KSIZE         = 3;
  localparam int EDGE          = 2;
  localparam int DATA_BITS     = 64;
  localparam int ADDR_BITS     = 6;

  typedef logic signed [PIXEL_BITS-1:0]  pixel_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_W_TOP   = 3'd2,
    REG_W_MID   = 3'd3,
    REG_W_BOT   = 3'd4
  } dwc_reg_e;

  typedef struct packed {
    pixel_t pixel;
    logic   frame_start;
  } dwc_in_t;

  typedef struct packed {
    sum_t conv_sum;
    logic frame_last;
  } dwc_out_t;

  typedef struct packed {
    logic shift;
    logic capture;
  } dwc_cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } dwc_tag_t;

  function automatic sum_t widen(prod_t p);
    return sum_t'(p);
  endfunction

endpackage

/* hw/rtl/dwc_line_buf.sv */
// Two line stores holding the previous two input rows, with one-deep write forwarding.
module dwc_line_buf import dwc_pkg::*; #(
  parameter int WIDTH_MAX = WIDTH_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [$clog2(WIDTH_MAX)-1:0] col,
  input  pixel_t                       pix,
  input  logic                         commit,
  output pixel_t                       top,
  output pixel_t                       mid
);

  localparam int COL_BITS = $clog2(WIDTH_MAX);

  pixel_t upper_mem [WIDTH_MAX];
  pixel_t lower_mem [WIDTH_MAX];

  pixel_t              top_rd_r;
  pixel_t              mid_rd_r;
  pixel_t              fwd_r;
  logic                fwd_hit_r;
  logic [COL_BITS-1:0] col_q_r;

  // lower row: read old, write new at the same column
  always_ff @(posedge clk) begin
    if (acc) begin
      top_rd_r <= upper_mem[col];
      mid_rd_r <= lower_mem[col];
      lower_mem[col] <= pix;
      col_q_r <= col;
      fwd_r <= mid_rd_r;
    end
    // upper row takes the old lower value one stage later
    if (commit) begin
      upper_mem[col_q_r] <= mid_rd_r;
    end
  end

  // same column read while its upper write is still in flight (restart mid-row)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (acc) begin
      fwd_hit_r <= commit && (col_q_r == col);
    end
  end

  assign top = fwd_hit_r ? fwd_r : top_rd_r;
  assign mid = mid_rd_r;

endmodule

/* hw/rtl/dwc_cell.sv */
// One window cell: holds a pixel, passes it left, registers its weighted product.
module dwc_cell import dwc_pkg::*; (
  input  logic           clk,
  input  dwc_cell_ctrl_t ctrl,
  input  pixel_t         pix_in,
  input  weight_t        weight,
  output pixel_t         pix_out,
  output prod_t          prod
);

  pixel_t pix_r;
  prod_t  prod_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pix_r <= pix_in;
    end
    if (ctrl.capture) begin
      prod_r <= prod_t'(pix_r) * prod_t'(weight);
    end
  end

  assign pix_out = pix_r;
  assign prod    = prod_r;

endmodule

/* hw/rtl/depthwise_conv3x3_stride1.sv */
// Top level of the 3x3 stride-1 valid depthwise convolution over one channel plane.
//
//  channel  ports                          payload
//  -------  -----------------------------  -------------------------------------------
//  input    in_valid / in_stall / in_data  pixel (Q8.8), frame_start
//  result   out_valid / out_stall /        conv_sum (36-bit Q14.22), frame_last
//           out_data
//  config   psel penable pwrite paddr      width, height, three weight rows at 8*i
//           pwdata prdata pready
//
// One pixel per clock is taken unless the pipeline holds; each result is registered
// through line-store read, window shift, multiply, row sums and final add.
// Reset is synchronous; it clears counters, stage tags and weights and sets width and
// height to 3. The line stores need no clearing pass: a column is always written before
// it is read. The whole pipeline advances together; it holds only while a result sits
// in the output register and out_stall is high, and in_stall follows exactly that.
module depthwise_conv3x3_stride1 import dwc_pkg::*; #(
  parameter int WIDTH_MAX = WIDTH_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dwc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dwc_out_t             out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int COL_BITS = $clog2(WIDTH_MAX);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0]  width_r;
  logic [DIM_BITS-1:0]  height_r;
  logic [WREG_BITS-1:0] wreg_r [KSIZE];
  logic                 cfg_wr;
  dwc_reg_e             reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = dwc_reg_e'(paddr[ADDR_BITS-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_BITS'(KSIZE);
      height_r <= DIM_BITS'(KSIZE);
      for (int r = 0; r < KSIZE; r++) begin
        wreg_r[r] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  width_r   <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT: height_r  <= pwdata[DIM_BITS-1:0];
        REG_W_TOP:  wreg_r[0] <= pwdata[WREG_BITS-1:0];
        REG_W_MID:  wreg_r[1] <= pwdata[WREG_BITS-1:0];
        REG_W_BOT:  wreg_r[2] <= pwdata[WREG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = DATA_BITS'(width_r);
      REG_HEIGHT: prdata = DATA_BITS'(height_r);
      REG_W_TOP:  prdata = DATA_BITS'(wreg_r[0]);
      REG_W_MID:  prdata = DATA_BITS'(wreg_r[1]);
      REG_W_BOT:  prdata = DATA_BITS'(wreg_r[2]);
      default:    prdata = '0;
    endcase
  end

  // Clamped last column / last row of the plane
  logic [COL_BITS-1:0] wm1;
  logic [ROW_BITS-1:0] hm1;

  always_comb begin
    if (width_r < DIM_BITS'(KSIZE)) begin
      wm1 = COL_BITS'(EDGE);
    end else if (32'(width_r) > 32'(WIDTH_MAX)) begin
      wm1 = COL_BITS'(WIDTH_MAX - 1);
    end else begin
      wm1 = COL_BITS'(width_r - 1'b1);
    end
    if (height_r < DIM_BITS'(KSIZE)) begin
      hm1 = ROW_BITS'(EDGE);
    end else if (height_r > DIM_BITS'(HEIGHT_LIMIT)) begin
      hm1 = ROW_BITS'(HEIGHT_LIMIT - 1);
    end else begin
      hm1 = ROW_BITS'(height_r - 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: everything moves unless a result is held at the output
  // ---------------------------------------------------------------------------
  logic     adv;
  logic     acc;
  logic     out_valid_r;
  dwc_out_t out_data_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign acc       = in_valid && adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Raster position; frame_start zeroes it before the pixel is placed
  // ---------------------------------------------------------------------------
  logic [COL_BITS-1:0] col_r, col_nxt, col_cur;
  logic [ROW_BITS-1:0] row_r, row_nxt, row_cur;
  logic                emit;
  logic                last;

  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_r;
    row_cur = in_data.frame_start ? '0 : row_r;
    emit    = (row_cur >= ROW_BITS'(EDGE)) && (col_cur >= COL_BITS'(EDGE));
    last    = (row_cur == hm1) && (col_cur == wm1);
    if (col_cur >= wm1) begin
      col_nxt = '0;
      row_nxt = (row_cur >= hm1) ? '0 : row_cur + 1'b1;
    end else begin
      col_nxt = col_cur + 1'b1;
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage tags: s1 line-store read, s2 window, s3 products, s4 row sums
  // ---------------------------------------------------------------------------
  dwc_tag_t s1_r, s2_r, s3_r, s4_r;
  logic     s1_emit_r;
  pixel_t   s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s1_emit_r   <= 1'b0;
      s2_r        <= '0;
      s3_r        <= '0;
      s4_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_r.valid  <= in_valid;
      s1_r.last   <= last;
      s1_emit_r   <= emit;
      // only items that produce a result travel past the window
      s2_r.valid  <= s1_r.valid && s1_emit_r;
      s2_r.last   <= s1_r.last;
      s3_r        <= s2_r;
      s4_r        <= s3_r;
      out_valid_r <= s4_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= in_data.pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores
  // ---------------------------------------------------------------------------
  pixel_t top_pix;
  pixel_t mid_pix;

  dwc_line_buf #(
    .WIDTH_MAX (WIDTH_MAX)
  ) u_line_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .col    (col_cur),
    .pix    (in_data.pixel),
    .commit (adv && s1_r.valid),
    .top    (top_pix),
    .mid    (mid_pix)
  );

  // ---------------------------------------------------------------------------
  // 3x3 chain of cells; column 2 is the newest, data moves right to left
  // ---------------------------------------------------------------------------
  dwc_cell_ctrl_t cell_ctrl;
  pixel_t         col_in [KSIZE];
  pixel_t         win    [KSIZE][KSIZE];
  prod_t          prod   [KSIZE][KSIZE];

  assign cell_ctrl.shift   = adv && s1_r.valid;
  assign cell_ctrl.capture = adv && s2_r.valid;

  assign col_in[0] = top_pix;
  assign col_in[1] = mid_pix;
  assign col_in[2] = s1_pix_r;

  for (genvar r = 0; r < KSIZE; r++) begin : g_row
    for (genvar c = 0; c < KSIZE; c++) begin : g_col
      pixel_t feed;
      if (c == KSIZE - 1) begin : g_head
        assign feed = col_in[r];
      end else begin : g_link
        assign feed = win[r][c+1];
      end
      dwc_cell u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .pix_in  (feed),
        .weight  (weight_t'(wreg_r[r][c*WEIGHT_BITS +: WEIGHT_BITS])),
        .pix_out (win[r][c]),
        .prod    (prod[r][c])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Adder: three row sums, then the total (wraps at 36 bits)
  // ---------------------------------------------------------------------------
  sum_t row_sum_r [KSIZE];

  always_ff @(posedge clk) begin
    if (adv && s3_r.valid) begin
      for (int r = 0; r < KSIZE; r++) begin
        row_sum_r[r] <= widen(prod[r][0]) + widen(prod[r][1]) + widen(prod[r][2]);
      end
    end
    if (adv && s4_r.valid) begin
      out_data_r.conv_sum   <= row_sum_r[0] + row_sum_r[1] + row_sum_r[2];
      out_data_r.frame_last <= s4_r.last;
    end
  end

endmodule

/* hw/rtl/dwc_checker.sv */
// Port-level checks of the depthwise convolution block, bound to its top level.
module dwc_checker import dwc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input dwc_out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input back-pressure comes only from a blocked result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without blocked output");

  // a pixel offered while the output drains is taken
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_stall |-> !in_stall)
    else $error("input refused while output free");

endmodule

bind depthwise_conv3x3_stride1 dwc_checker u_dwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
